// ===== rtl/core/bmrg_pkg.sv =====
// ----------------------------------------------------------------------------
// bmrg_pkg - bank mapper shared definitions
// Op codes, register map, guard keys and the PRG bank remap function.
// ----------------------------------------------------------------------------
package bmrg_pkg;

	localparam int RAM_DEPTH   = 8192;
	localparam int RAM_AW      = $clog2(RAM_DEPTH);
	localparam int LATCH_COUNT = 8;
	localparam int LATCH_AW    = $clog2(LATCH_COUNT);
	localparam int REG_COUNT   = 15;
	localparam int CNT_W       = 13;

	// op codes
	localparam logic [2:0] OP_CPU_READ  = 3'd0;
	localparam logic [2:0] OP_CPU_WRITE = 3'd1;
	localparam logic [2:0] OP_CPU_TICK  = 3'd2;
	localparam logic [2:0] OP_PRG_XLATE = 3'd3;
	localparam logic [2:0] OP_CHR_XLATE = 3'd4;

	// configuration register indexes
	localparam logic CFG_RAM_PRESENT = 1'b0;
	localparam logic CFG_REV_PRG     = 1'b1;

	// control register map
	localparam logic [3:0] R_MODE      = 4'd6;
	localparam logic [3:0] R_GUARD_A   = 4'd7;
	localparam logic [3:0] R_GUARD_B   = 4'd8;
	localparam logic [3:0] R_GUARD_C   = 4'd9;
	localparam logic [3:0] R_PRG0      = 4'd10;
	localparam logic [3:0] R_PRG1      = 4'd11;
	localparam logic [3:0] R_PRG2      = 4'd12;
	localparam logic [3:0] R_IRQ_LATCH = 4'd13;
	localparam logic [3:0] R_IRQ_CTRL  = 4'd14;

	localparam logic [7:0] GUARD_A_KEY = 8'hCA;
	localparam logic [7:0] GUARD_B_KEY = 8'h69;
	localparam logic [7:0] GUARD_C_KEY = 8'h84;
	localparam logic [7:0] PRG1_RST    = 8'h01;
	localparam logic [7:0] PRG2_RST    = 8'hFE;
	localparam logic [7:0] FIXED_BANK  = 8'hFF;

	localparam logic [15:0] REG_BASE   = 16'h7EF0;
	localparam logic [15:0] RELOAD_ADR = 16'h7EFF;
	localparam logic [CNT_W-1:0] TICK_ZERO_LOAD = 13'd17;

	// Bank number from a PRG register: six bits mirrored, or value >> 2.
	function automatic logic [7:0] prg_map(input logic [7:0] v, input logic rev);
		logic [7:0] r;
		if (rev) begin
			r = {2'b00, v[0], v[1], v[2], v[3], v[4], v[5]};
		end else begin
			r = {2'b00, v[7:2]};
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/bank_mapper_ram_guard_irq_top.sv =====
// ----------------------------------------------------------------------------
// bank_mapper_ram_guard_irq_top - bank mapper with guarded work RAM and IRQ
// Register file, three key-guarded RAM windows with per-1K latches, a 13-bit
// CPU-cycle down counter and PRG/CHR bank translation on a beat stream.
// ----------------------------------------------------------------------------
// Usage: one op beat in on s_*, one result beat out on m_* per op, in order.
// The block takes a new beat every clock as long as the result side keeps
// up; on the accepting edge the op is registered in stage 1 with the RAM
// read, and from there the result beat goes to the output register. Throughput
// is set by the single work RAM port, which serves one read or one write per
// clock.
// After reset the work RAM is swept to zero, one byte per clock, so s_tready
// stays low until the sweep is done; cfg writes are taken during that sweep.
// A byte read from RAM reaches its 1K latch when the read leaves stage 1; a
// read of the same latch by the very next op is forwarded from the RAM data
// register.
// cfg_we/cfg_index/cfg_data: index 0 ram_present, index 1 reversed_prg_bits.
module bank_mapper_ram_guard_irq_top
	import bmrg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // op[2:0], addr[18:3], wdata[26:19], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // read_data[7:0], bank[15:8], vertical_mirror[16],
	                               // irq_n[17], zero pad
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic        cfg_data
);

	// ---------------- configuration ----------------
	logic ram_present_q;
	logic rev_prg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_present_q <= 1'b1;
			rev_prg_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RAM_PRESENT: ram_present_q <= cfg_data;
				CFG_REV_PRG:     rev_prg_q     <= cfg_data;
				default:         ;
			endcase
		end
	end

	// ---------------- state ----------------
	logic [7:0]       cr_q    [REG_COUNT];
	logic [7:0]       latch_q [LATCH_COUNT];
	logic [CNT_W-1:0] cnt_q;
	logic             irq_line_q;

	// post-reset RAM sweep
	logic [RAM_AW-1:0] clr_cnt_q;
	logic              clr_busy_q;

	// pipeline
	logic                v_s1;
	logic                ramrd_s1;
	logic [LATCH_AW-1:0] li_s1;
	logic [7:0]          rd_s1;
	logic [7:0]          bank_s1;
	logic                vm_s1;
	logic                irq_s1;
	logic                out_v_q;
	logic [23:0]         out_data_q;
	logic [7:0]          ram_q;

	logic s1_adv;
	logic acc;

	assign s1_adv   = v_s1 && (!out_v_q || m_tready);
	assign s_tready = !clr_busy_q && (!v_s1 || s1_adv);
	assign acc      = s_tvalid && s_tready;

	// ---------------- input decode ----------------
	logic [2:0]          op;
	logic [15:0]         a;
	logic [7:0]          wd;
	logic [LATCH_AW-1:0] li;
	logic [RAM_AW-1:0]   ri;
	logic                guarded;
	logic                reg_hit;
	logic                reload_hit;

	assign op = s_tdata[2:0];
	assign a  = s_tdata[18:3];
	assign wd = s_tdata[26:19];
	assign li = a[10 +: LATCH_AW];
	assign ri = a[RAM_AW-1:0];

	always_comb begin
		guarded = 1'b0;
		if (a[15:11] == 5'b01100 && cr_q[R_GUARD_A] == GUARD_A_KEY) guarded = 1'b1;
		if (a[15:11] == 5'b01101 && cr_q[R_GUARD_B] == GUARD_B_KEY) guarded = 1'b1;
		if (a[15:10] == 6'b011100 && cr_q[R_GUARD_C] == GUARD_C_KEY) guarded = 1'b1;
	end

	assign reg_hit    = (a[15:4] == REG_BASE[15:4]) && (a != RELOAD_ADR);
	assign reload_hit = (a == RELOAD_ADR);

	logic is_rd, is_wr, is_tick;
	logic rd_open;      // guarded read with RAM fitted
	logic rd_ram;       // goes to RAM
	logic wr_latch;     // guarded write
	logic wr_reg;
	logic wr_reload;

	assign is_rd     = acc && (op == OP_CPU_READ);
	assign is_wr     = acc && (op == OP_CPU_WRITE);
	assign is_tick   = acc && (op == OP_CPU_TICK);
	assign rd_open   = ram_present_q && guarded;
	assign rd_ram    = is_rd && rd_open && (a[9:0] != 10'd0);
	assign wr_latch  = is_wr && guarded;
	assign wr_reg    = is_wr && !guarded && reg_hit;
	assign wr_reload = is_wr && !guarded && reload_hit;

	// latch read, forwarding the byte still on its way from RAM
	logic [7:0] lat_rd;
	assign lat_rd = (v_s1 && ramrd_s1 && li_s1 == li) ? ram_q : latch_q[li];

	// ---------------- IRQ counter ----------------
	logic [7:0]       irq_l;
	logic [7:0]       irq_c;
	logic [CNT_W-1:0] cnt_d;
	logic             irq_line_d;

	assign irq_l = cr_q[R_IRQ_LATCH];
	assign irq_c = cr_q[R_IRQ_CTRL];

	always_comb begin
		cnt_d      = cnt_q;
		irq_line_d = irq_line_q;
		if (wr_reload) begin
			cnt_d = (irq_l == 8'd0) ? CNT_W'(1) : {({1'b0, irq_l} + 9'd1), 4'b0000};
		end
		if (is_tick) begin
			if (irq_c[0] && !irq_c[2]) begin
				if (cnt_q != '0) cnt_d = cnt_q - CNT_W'(1);
			end else begin
				cnt_d = (irq_l == 8'd0) ? TICK_ZERO_LOAD
				                        : {({1'b0, irq_l} + 9'd2), 4'b0000};
			end
			irq_line_d = !(irq_c[1] && cnt_d == '0);
		end
	end

	// ---------------- translation ----------------
	logic [2:0] chr_k;
	logic [3:0] chr_idx;
	logic [3:0] tr_idx;
	logic [7:0] tr_val;
	logic [7:0] bank_d;

	assign chr_k   = a[12:10] ^ {cr_q[R_MODE][1], 2'b00};
	assign chr_idx = chr_k[2] ? ({1'b0, chr_k} - 4'd2) : {3'b000, chr_k[1]};
	assign tr_idx  = (op == OP_PRG_XLATE) ? (R_PRG0 + {2'b00, a[14:13]}) : chr_idx;
	assign tr_val  = cr_q[tr_idx];

	always_comb begin
		bank_d = 8'd0;
		case (op)
			OP_PRG_XLATE: begin
				if (a[15]) begin
					bank_d = (a[14:13] == 2'b11) ? FIXED_BANK : prg_map(tr_val, rev_prg_q);
				end
			end
			OP_CHR_XLATE: begin
				bank_d = chr_k[2] ? tr_val : {tr_val[7:1], chr_k[0]};
			end
			default: bank_d = 8'd0;
		endcase
	end

	// mirroring bit as it stands after this op
	logic vm_d;
	assign vm_d = (wr_reg && a[3:0] == R_MODE) ? wd[0] : cr_q[R_MODE][0];

	// ---------------- register file, latches, counter ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++)
				cr_q[i] <= (4'(i) == R_PRG1) ? PRG1_RST :
				           ((4'(i) == R_PRG2) ? PRG2_RST : 8'd0);
			for (int i = 0; i < LATCH_COUNT; i++) latch_q[i] <= 8'd0;
			cnt_q      <= '0;
			irq_line_q <= 1'b1;
		end else begin
			if (wr_reg) cr_q[a[3:0]] <= wd;
			// a newer write to the same latch takes precedence over the older RAM read
			if (s1_adv && ramrd_s1 && !(wr_latch && li == li_s1)) latch_q[li_s1] <= ram_q;
			if (wr_latch) latch_q[li] <= wd;
			cnt_q      <= cnt_d;
			irq_line_q <= irq_line_d;
		end
	end

	// ---------------- work RAM ----------------
	logic [7:0]        ram_mem [RAM_DEPTH];
	logic              ram_we;
	logic [RAM_AW-1:0] ram_wa;
	logic [7:0]        ram_wd;

	assign ram_we = clr_busy_q || (wr_latch && ram_present_q);
	assign ram_wa = clr_busy_q ? clr_cnt_q : ri;
	assign ram_wd = clr_busy_q ? 8'd0 : wd;

	always_ff @(posedge clk) begin
		if (ram_we) ram_mem[ram_wa] <= ram_wd;
		if (rd_ram) ram_q <= ram_mem[ri];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + RAM_AW'(1);
			if (clr_cnt_q == {RAM_AW{1'b1}}) clr_busy_q <= 1'b0;
		end
	end

	// ---------------- stage 1 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ramrd_s1 <= rd_ram;
			li_s1    <= li;
			rd_s1    <= (is_rd && rd_open) ? lat_rd : 8'd0;
			bank_s1  <= bank_d;
			vm_s1    <= vm_d;
			irq_s1   <= irq_line_d;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_adv) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_data_q <= {6'd0, irq_s1, vm_s1, bank_s1, (ramrd_s1 ? ram_q : rd_s1)};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;

`ifndef SYNTHESIS
	// the RAM sweep runs once after reset
	a_clr_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_busy_q |=> !clr_busy_q)
		else $error("RAM clear restarted");

	// a RAM byte read lands in its latch unless a newer write takes it over
	a_latch_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && ramrd_s1 && !(wr_latch && li == li_s1))
		|=> latch_q[$past(li_s1)] == $past(ram_q))
		else $error("latch missed RAM read data");

	// counter never exceeds the largest preload
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(4112))
		else $error("IRQ counter out of range");

	// no RAM read or write by an op while the sweep owns the RAM port
	a_no_acc_clr: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_ram || wr_latch) |-> !clr_busy_q)
		else $error("RAM access during clear");
`endif

endmodule

// ===== dv/bank_mapper_ram_guard_irq_checker.sv =====
// ----------------------------------------------------------------------------
// bank_mapper_ram_guard_irq_checker - result checker for the bank mapper
// Watches the op, result and cfg ports and keeps a cycle-free copy of the
// mapper state. It queues the expected result beats and checks them in order.
// ----------------------------------------------------------------------------
module bank_mapper_ram_guard_irq_checker
	import bmrg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic        cfg_data,
	output int          mismatches,
	output int          pending
);

	// irq control and mode register bits
	localparam int CTRL_COUNT = 0;
	localparam int CTRL_EN    = 1;
	localparam int CTRL_SRC   = 2;
	localparam int MODE_VMIR  = 0;
	localparam int MODE_FLIP  = 1;

	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] bank;
		logic       vmirror;
		logic       irq_n;
	} mapper_result_t;

	logic [7:0]       ctl [REG_COUNT];
	logic [7:0]       blk_latch [LATCH_COUNT];
	logic [7:0]       wram [RAM_DEPTH];
	logic [CNT_W-1:0] down_cnt;
	logic             irq_line;
	logic             ram_on;
	logic             rev_prg;

	mapper_result_t   pending_results[$];
	mapper_result_t   want;
	mapper_result_t   got;
	int               errs;

	function automatic logic window_open(input logic [15:0] a);
		return (a >= 16'h6000 && a <= 16'h67FF && ctl[R_GUARD_A] == GUARD_A_KEY) ||
		       (a >= 16'h6800 && a <= 16'h6FFF && ctl[R_GUARD_B] == GUARD_B_KEY) ||
		       (a >= 16'h7000 && a <= 16'h73FF && ctl[R_GUARD_C] == GUARD_C_KEY);
	endfunction

	function automatic logic [7:0] prg_bank(input logic [7:0] v);
		logic [7:0] b;
		b = '0;
		if (rev_prg) begin
			for (int i = 0; i < 6; i++) b[5 - i] = v[i];
		end else begin
			b = v >> 2;
		end
		return b;
	endfunction

	// one op against the state copy; returns the result beat it should produce
	task automatic run_mapper_op(input logic [2:0] op, input logic [15:0] a,
	                             input logic [7:0] wd, output mapper_result_t r);
		logic [LATCH_AW-1:0] li;
		logic [RAM_AW-1:0]   ri;
		logic [7:0]          c;
		logic [7:0]          l;
		logic [8:0]          lp;
		logic [1:0]          s;
		logic [2:0]          k;
		li = a[10 +: LATCH_AW];
		ri = a[RAM_AW-1:0];
		r  = '0;
		case (op)
			OP_CPU_READ: begin
				if (ram_on && window_open(a)) begin
					if (a[9:0] != 10'd0) begin
						blk_latch[li] = wram[ri];
						r.read_data   = wram[ri];
					end else begin
						r.read_data = blk_latch[li];
					end
				end
			end
			OP_CPU_WRITE: begin
				if (window_open(a)) begin
					blk_latch[li] = wd;
					if (ram_on) wram[ri] = wd;
				end else if (a >= REG_BASE && a < RELOAD_ADR) begin
					ctl[a - REG_BASE] = wd;
				end else if (a == RELOAD_ADR) begin
					l  = ctl[R_IRQ_LATCH];
					lp = {1'b0, l} + 9'd1;
					down_cnt = (l != 8'd0) ? {lp, 4'b0000} : CNT_W'(1);
				end
			end
			OP_CPU_TICK: begin
				c = ctl[R_IRQ_CTRL];
				if (c[CTRL_COUNT] && !c[CTRL_SRC]) begin
					if (down_cnt != '0) down_cnt = down_cnt - 1'b1;
				end else begin
					l  = ctl[R_IRQ_LATCH];
					lp = {1'b0, l} + 9'd2;
					down_cnt = (l != 8'd0) ? {lp, 4'b0000} : TICK_ZERO_LOAD;
				end
				irq_line = !(c[CTRL_EN] && down_cnt == '0);
			end
			OP_PRG_XLATE: begin
				if (a[15]) begin
					s = a[14:13];
					r.bank = (s == 2'd3) ? FIXED_BANK : prg_bank(ctl[R_PRG0 + s]);
				end
			end
			OP_CHR_XLATE: begin
				k = a[12:10] ^ (ctl[R_MODE][MODE_FLIP] ? 3'd4 : 3'd0);
				// 2K regs cover the low half: even bank plus the 1K offset
				if (!k[2]) r.bank = {ctl[k[1]][7:1], k[0]};
				else       r.bank = ctl[k - 3'd2];
			end
			default: ;
		endcase
		r.vmirror = ctl[R_MODE][MODE_VMIR];
		r.irq_n   = irq_line;
	endtask

	task automatic check_field(input string what, input logic [7:0] exp_v,
	                           input logic [7:0] act_v);
		if (exp_v !== act_v) begin
			errs++;
			$display("%0t: %s expected %02h actual %02h", $time, what, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (ctl[i]) ctl[i] = '0;
			ctl[R_PRG1] = PRG1_RST;
			ctl[R_PRG2] = PRG2_RST;
			foreach (blk_latch[i]) blk_latch[i] = '0;
			foreach (wram[i]) wram[i] = '0;
			down_cnt = '0;
			irq_line = 1'b1;
			ram_on   = 1'b1;
			rev_prg  = 1'b0;
			pending_results.delete();
			errs = 0;
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_RAM_PRESENT) ram_on  = cfg_data;
				else                              rev_prg = cfg_data;
			end
			if (m_tvalid && m_tready) begin
				got = '{read_data: m_tdata[7:0], bank: m_tdata[15:8],
				        vmirror: m_tdata[16], irq_n: m_tdata[17]};
				if (pending_results.size() == 0) begin
					errs++;
					$display("%0t: result beat with nothing expected, actual %06h",
					         $time, m_tdata);
				end else begin
					want = pending_results.pop_front();
					check_field("read_data", want.read_data, got.read_data);
					check_field("bank", want.bank, got.bank);
					check_field("vertical_mirror", 8'(want.vmirror), 8'(got.vmirror));
					check_field("irq_n", 8'(want.irq_n), 8'(got.irq_n));
				end
			end
			if (s_tvalid && s_tready) begin
				run_mapper_op(s_tdata[2:0], s_tdata[18:3], s_tdata[26:19], want);
				pending_results.push_back(want);
			end
			mismatches <= errs;
			pending    <= pending_results.size();
		end
	end

endmodule

// ===== dv/bank_mapper_ram_guard_irq_top_tb.sv =====
// ----------------------------------------------------------------------------
// bank_mapper_ram_guard_irq_top_tb - testbench top for the bank mapper
// Drives op beats with random gaps and result back-pressure, walks the cfg
// bits through every combination, and lets the checker judge each result.
// ----------------------------------------------------------------------------
module bank_mapper_ram_guard_irq_top_tb;
	import bmrg_pkg::*;

	// slow bound: the RAM sweep, then ~700 beats each losing up to the longest
	// send gap plus the longest result stall, plus cfg pauses
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASE_BEATS = 150;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        cfg_we;
	logic        cfg_index;
	logic        cfg_data;

	int mismatches;
	int pending;
	int cycles;
	bit calm;      // no gaps or stalls while set

	int n_ops, n_reads, n_writes, n_ticks, n_xlates;

	bank_mapper_ram_guard_irq_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bank_mapper_ram_guard_irq_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog: nothing may hang the run
	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
		$display("end of test: mismatches");
		$finish;
	end

	// mostly short idles, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// result side back-pressure
	initial begin : ready_gen
		int run;
		int stall;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			run = calm ? 16 : $urandom_range(1, 12);
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			stall = calm ? 0 : idle_len();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// one op beat; returns at the edge where it is taken. s_tvalid gets a
	// single NBA per step so back-to-back beats keep it high
	task automatic send_op(input logic [2:0] op, input logic [15:0] a, input logic [7:0] wd);
		int gap;
		gap = calm ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, wd, a, op};
		do @(posedge clk); while (!s_tready);
		n_ops++;
		case (op)
			OP_CPU_READ:  n_reads++;
			OP_CPU_WRITE: n_writes++;
			OP_CPU_TICK:  n_ticks++;
			default:      n_xlates++;
		endcase
	endtask

	// cfg bits only move while the mapper is drained
	task automatic set_cfg(input logic idx, input logic val);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// address in one of the five guarded 1K blocks; mostly a few hot bytes so
	// reads land on written data, sometimes the latch slot at offset zero
	function automatic logic [15:0] window_addr();
		logic [15:0] a;
		a = 16'h6000 + 16'($urandom_range(0, 4)) * 16'h0400;
		if ($urandom_range(0, 9) < 7) a = a + 16'($urandom_range(0, 15));
		else                          a = a + 16'($urandom_range(0, 16'h3FF));
		if ($urandom_range(0, 5) == 0) a[9:0] = '0;
		return a;
	endfunction

	// register write data: guards mostly get their key, the irq latch small
	// values so the counter reaches zero in reasonable time
	function automatic logic [7:0] reg_value(input logic [3:0] ri);
		logic [7:0] v;
		v = 8'($urandom);
		case (ri)
			R_GUARD_A:   if ($urandom_range(0, 99) < 85) v = GUARD_A_KEY;
			R_GUARD_B:   if ($urandom_range(0, 99) < 85) v = GUARD_B_KEY;
			R_GUARD_C:   if ($urandom_range(0, 99) < 85) v = GUARD_C_KEY;
			R_IRQ_LATCH: if ($urandom_range(0, 9) < 7) v = 8'($urandom_range(0, 3));
			R_IRQ_CTRL:  if ($urandom_range(0, 1) == 0) v[2:0] = 3'b011;  // count + enable
			default: ;
		endcase
		return v;
	endfunction

	task automatic random_phase(input int count);
		int          done;
		int          kind;
		int          burst;
		logic [2:0]  op;
		logic [15:0] a;
		logic [7:0]  wd;
		logic [3:0]  ri;
		done = 0;
		while (done < count) begin
			kind  = $urandom_range(0, 99);
			wd    = 8'($urandom);
			burst = 1;
			if (kind < 30) begin
				op = OP_CPU_READ;
				a  = window_addr();
			end else if (kind < 50) begin
				op = OP_CPU_WRITE;
				a  = window_addr();
			end else if (kind < 60) begin
				op = OP_CPU_WRITE;
				ri = 4'($urandom_range(0, REG_COUNT - 1));
				a  = REG_BASE + 16'(ri);
				wd = reg_value(ri);
			end else if (kind < 63) begin
				op = OP_CPU_WRITE;
				a  = RELOAD_ADR;
			end else if (kind < 78) begin
				// tick runs, some long enough to drain the counter
				op    = OP_CPU_TICK;
				a     = 16'($urandom);
				burst = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4)
				                                   : $urandom_range(8, 48);
			end else if (kind < 86) begin
				op = OP_PRG_XLATE;
				a  = 16'($urandom);
				if ($urandom_range(0, 4) != 0) a[15] = 1'b1;
			end else if (kind < 94) begin
				op = OP_CHR_XLATE;
				a  = 16'($urandom);
			end else begin
				// noise: any op anywhere
				op = 3'($urandom_range(OP_CPU_READ, OP_CHR_XLATE));
				a  = 16'($urandom);
			end
			repeat (burst) begin
				send_op(op, a, wd);
				done++;
			end
		end
	endtask

	initial begin : stimulus
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= 1'b0;
		cfg_data  <= 1'b0;
		calm = 1'b0;
		n_ops = 0; n_reads = 0; n_writes = 0; n_ticks = 0; n_xlates = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// cfg is taken during the RAM sweep; restate the reset values
		set_cfg(CFG_RAM_PRESENT, 1'b1);
		set_cfg(CFG_REV_PRG, 1'b0);

		// --- directed ---
		send_op(OP_CPU_READ, 16'h6001, 8'h00);         // window still locked
		send_op(OP_CPU_READ, REG_BASE, 8'h00);         // register space reads 0
		send_op(OP_PRG_XLATE, 16'h0000, 8'h00);        // below PRG space
		send_op(OP_PRG_XLATE, 16'h8000, 8'h00);
		send_op(OP_PRG_XLATE, 16'hA000, 8'h00);
		send_op(OP_PRG_XLATE, 16'hC000, 8'h00);
		send_op(OP_PRG_XLATE, 16'hFFFF, 8'h00);        // fixed last bank
		send_op(OP_CHR_XLATE, 16'h0000, 8'h00);
		send_op(OP_CHR_XLATE, 16'hFC00, 8'h00);        // high bits wrap
		send_op(OP_CPU_WRITE, REG_BASE + 16'(R_GUARD_A), GUARD_A_KEY);
		send_op(OP_CPU_WRITE, REG_BASE + 16'(R_GUARD_B), GUARD_B_KEY);
		send_op(OP_CPU_WRITE, REG_BASE + 16'(R_GUARD_C), GUARD_C_KEY);
		send_op(OP_CPU_WRITE, 16'h6005, 8'hA5);
		send_op(OP_CPU_READ, 16'h6005, 8'h00);
		send_op(OP_CPU_READ, 16'h6000, 8'h00);         // latch slot
		send_op(OP_CPU_WRITE, 16'h73FF, 8'hFF);        // top of window C
		send_op(OP_CPU_READ, 16'h7000, 8'h00);
		send_op(OP_CPU_READ, 16'h7400, 8'h00);         // just past window C
		send_op(OP_CPU_WRITE, REG_BASE + 16'(R_MODE), 8'h03);  // vmirror + chr flip
		send_op(OP_CHR_XLATE, 16'h1000, 8'h00);
		send_op(OP_CPU_WRITE, REG_BASE + 16'(R_IRQ_LATCH), 8'h00);
		send_op(OP_CPU_WRITE, RELOAD_ADR, 8'h00);      // zero latch reloads 1
		send_op(OP_CPU_WRITE, REG_BASE + 16'(R_IRQ_CTRL), 8'h03);
		send_op(OP_CPU_TICK, 16'h0000, 8'h00);
		send_op(OP_CPU_TICK, 16'h0000, 8'h00);         // held at zero, irq low
		send_op(OP_CPU_WRITE, REG_BASE + 16'(R_IRQ_CTRL), 8'h04);  // other source
		send_op(OP_CPU_TICK, 16'hFFFF, 8'h00);         // preload path
		send_op(OP_CPU_WRITE, 16'h5000, 8'h5A);        // outside mapper space

		// --- random, one phase per cfg setting ---
		for (int ph = 0; ph < 4; ph++) begin
			set_cfg(CFG_RAM_PRESENT, ph[0] ^ ph[1] ^ 1'b1);
			set_cfg(CFG_REV_PRG, !ph[1]);
			calm = (ph == 2);
			random_phase(PHASE_BEATS);
		end
		calm = 1'b0;

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("sent %0d ops: %0d reads, %0d writes, %0d ticks, %0d translates",
		         n_ops, n_reads, n_writes, n_ticks, n_xlates);
		$display("all four ram_present / reversed_prg_bits settings, with and without idles");
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== bank_mapper_ram_guard_irq_top.f =====
rtl/core/bmrg_pkg.sv
rtl/core/bank_mapper_ram_guard_irq_top.sv
dv/bank_mapper_ram_guard_irq_checker.sv
dv/bank_mapper_ram_guard_irq_top_tb.sv
